### rtl/mlpq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the multi-level priority queue.
// No dependencies; used by the level control and the top level.
package mlpq_pkg;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_BAD_LEVEL = 2'd3
	} status_t;

	localparam logic ACT_ENQUEUE = 1'b0;
	localparam logic ACT_DEQUEUE = 1'b1;

	localparam logic REG_LEVELS_IN_USE  = 1'b0;
	localparam logic REG_LEVEL_CAPACITY = 1'b1;

	localparam int LEVEL_FIELD_W = 4;
	localparam int LEVELS_CFG_W  = 4;
	localparam int CAP_CFG_W     = 5;
	localparam int CFG_DATA_W    = 5;

	localparam logic [LEVELS_CFG_W-1:0] LEVELS_RESET   = 4'd8;
	localparam logic [CAP_CFG_W-1:0]    CAPACITY_RESET = 5'd16;

	typedef struct packed {
		logic                     wr;
		logic                     rd;
		status_t                  status;
		logic [LEVEL_FIELD_W-1:0] served;
	} mlpq_dec_t;

endpackage

### rtl/mlpq_store.sv
`timescale 1ns / 1ps
// Entry storage of all levels: one write port and one registered read port.
// Stand-alone module with no package dependency.
module mlpq_store #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 32,
	parameter int AW    = 7
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/mlpq_ctrl.sv
`timescale 1ns / 1ps
// Per-level head, tail and fill count, with the decision logic of one transaction.
// Depends on mlpq_pkg for the status codes and the decision struct.
module mlpq_ctrl #(
	parameter int MAX_LEVELS  = 8,
	parameter int LEVEL_DEPTH = 16,
	parameter int AW          = 7
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  go,
	input  logic                                  action,
	input  logic [mlpq_pkg::LEVEL_FIELD_W-1:0]    level,
	input  logic [mlpq_pkg::LEVELS_CFG_W-1:0]     levels_in_use,
	input  logic [mlpq_pkg::CAP_CFG_W-1:0]        level_capacity,
	output mlpq_pkg::mlpq_dec_t                   dec,
	output logic [AW-1:0]                         wr_addr,
	output logic [AW-1:0]                         rd_addr
);
	import mlpq_pkg::*;

	localparam int PTR_W   = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
	localparam int CNT_W   = $clog2(LEVEL_DEPTH + 1);
	localparam int LVL_W   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int NL_RAW  = $clog2(MAX_LEVELS + 1);
	localparam int NL_W    = (NL_RAW > LEVEL_FIELD_W) ? NL_RAW : LEVEL_FIELD_W;
	localparam int CAP_W   = (CNT_W > CAP_CFG_W) ? CNT_W : CAP_CFG_W;

	logic [PTR_W-1:0] head_q [MAX_LEVELS];
	logic [PTR_W-1:0] tail_q [MAX_LEVELS];
	logic [CNT_W-1:0] fill_q [MAX_LEVELS];

	logic [NL_W-1:0]  nlev;
	logic [CAP_W-1:0] cap_ext;
	logic [CNT_W-1:0] eff_cap;
	logic [NL_W-1:0]  level_ext;
	logic [LVL_W-1:0] enq_idx;
	logic [LVL_W-1:0] deq_idx;
	logic             found;
	logic             bad_level;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		r = (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + PTR_W'(1);
		return r;
	endfunction

	always_comb begin
		nlev = (NL_W'(levels_in_use) > NL_W'(MAX_LEVELS)) ? NL_W'(MAX_LEVELS)
			: NL_W'(levels_in_use);
		cap_ext = CAP_W'(level_capacity);
		eff_cap = (cap_ext > CAP_W'(LEVEL_DEPTH)) ? CNT_W'(LEVEL_DEPTH) : CNT_W'(cap_ext);
		level_ext = NL_W'(level);
		bad_level = (level_ext == '0) || (level_ext > nlev);
		enq_idx = LVL_W'(level_ext - NL_W'(1));
	end

	always_comb begin
		found = 1'b0;
		deq_idx = '0;
		for (int i = 0; i < MAX_LEVELS; i++) begin
			if (!found && (NL_W'(i) < nlev) && (fill_q[i] != '0)) begin
				found = 1'b1;
				deq_idx = LVL_W'(i);
			end
		end
	end

	always_comb begin
		dec.wr = 1'b0;
		dec.rd = 1'b0;
		dec.status = ST_OK;
		dec.served = '0;
		if (action == ACT_ENQUEUE) begin
			if (bad_level) begin
				dec.status = ST_BAD_LEVEL;
			end else if (fill_q[enq_idx] >= eff_cap) begin
				dec.status = ST_FULL;
			end else begin
				dec.wr = 1'b1;
			end
		end else begin
			if (found) begin
				dec.rd = 1'b1;
				dec.served = LEVEL_FIELD_W'(deq_idx) + LEVEL_FIELD_W'(1);
			end else begin
				dec.status = ST_EMPTY;
			end
		end
	end

	assign wr_addr = AW'(AW'(enq_idx) * AW'(LEVEL_DEPTH) + AW'(tail_q[enq_idx]));
	assign rd_addr = AW'(AW'(deq_idx) * AW'(LEVEL_DEPTH) + AW'(head_q[deq_idx]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else if (go) begin
			if (dec.wr) begin
				tail_q[enq_idx] <= next_ptr(tail_q[enq_idx]);
				fill_q[enq_idx] <= fill_q[enq_idx] + CNT_W'(1);
			end
			if (dec.rd) begin
				fill_q[deq_idx] <= fill_q[deq_idx] - CNT_W'(1);
				if (fill_q[deq_idx] == CNT_W'(1)) begin
					head_q[deq_idx] <= '0;
					tail_q[deq_idx] <= '0;
				end else begin
					head_q[deq_idx] <= next_ptr(head_q[deq_idx]);
				end
			end
		end
	end

endmodule

### rtl/multi_level_priority_fifo_top.sv
`timescale 1ns / 1ps
// Top level of the strict-priority multi-level queue.
// Depends on mlpq_pkg, mlpq_ctrl and mlpq_store.
// The queue takes one transaction per clock while cmd_stall is low. After acceptance,
// an input register feeds the level decision (a priority encode over
// the level fill counts) and one access to the shared entry memory, and the result
// register holds the answer until the result channel takes it. Enqueue appends to the
// FIFO of its level; dequeue serves the lowest-numbered non-empty active level.
module multi_level_priority_fifo_top #(
	parameter int MAX_LEVELS  = 8,
	parameter int LEVEL_DEPTH = 16,
	parameter int DATA_WIDTH  = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_write,
	input  logic                                   cfg_index,
	input  logic [mlpq_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                   cmd_valid,
	output logic                                   cmd_stall,
	input  logic                                   action,
	input  logic signed [DATA_WIDTH-1:0]           element,
	input  logic [mlpq_pkg::LEVEL_FIELD_W-1:0]     target_level,
	output logic                                   res_valid,
	input  logic                                   res_stall,
	output logic [1:0]                             status,
	output logic signed [DATA_WIDTH-1:0]           data_out,
	output logic [mlpq_pkg::LEVEL_FIELD_W-1:0]     served_level
);
	import mlpq_pkg::*;

	localparam int STORE_DEPTH = MAX_LEVELS * LEVEL_DEPTH;
	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	logic [LEVELS_CFG_W-1:0]  levels_in_use_q;
	logic [CAP_CFG_W-1:0]     level_capacity_q;

	logic                     valid_s1;
	logic                     action_s1;
	logic [DATA_WIDTH-1:0]    element_s1;
	logic [LEVEL_FIELD_W-1:0] level_s1;

	logic                     valid_s2;
	status_t                  status_s2;
	logic [LEVEL_FIELD_W-1:0] served_s2;
	logic                     show_s2;

	logic                     adv;
	logic                     go;
	logic                     accept;
	mlpq_dec_t                dec;
	logic [AW-1:0]            wr_addr;
	logic [AW-1:0]            rd_addr;
	logic [DATA_WIDTH-1:0]    rdata;

	assign adv       = !valid_s2 || !res_stall;
	assign go        = valid_s1 && adv;
	assign cmd_stall = valid_s1 && !adv;
	assign accept    = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_in_use_q  <= LEVELS_RESET;
			level_capacity_q <= CAPACITY_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_LEVELS_IN_USE:  levels_in_use_q  <= cfg_data[LEVELS_CFG_W-1:0];
				REG_LEVEL_CAPACITY: level_capacity_q <= cfg_data[CAP_CFG_W-1:0];
				default:            level_capacity_q <= level_capacity_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1  <= action;
			element_s1 <= element;
			level_s1   <= target_level;
		end
	end

	mlpq_ctrl #(
		.MAX_LEVELS  (MAX_LEVELS),
		.LEVEL_DEPTH (LEVEL_DEPTH),
		.AW          (AW)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.go             (go),
		.action         (action_s1),
		.level          (level_s1),
		.levels_in_use  (levels_in_use_q),
		.level_capacity (level_capacity_q),
		.dec            (dec),
		.wr_addr        (wr_addr),
		.rd_addr        (rd_addr)
	);

	mlpq_store #(
		.DEPTH (STORE_DEPTH),
		.WIDTH (DATA_WIDTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (go && dec.wr),
		.waddr (wr_addr),
		.wdata (element_s1),
		.re    (go && dec.rd),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			status_s2 <= dec.status;
			served_s2 <= dec.served;
			show_s2   <= dec.rd;
		end
	end

	assign res_valid    = valid_s2;
	assign status       = status_s2;
	assign served_level = served_s2;
	assign data_out     = show_s2 ? rdata : '0;

endmodule
